// File: hw/rtl/dce_pkg.sv
// Shared types, constants and tables of the dislocation correlation evaluator.
package dce_pkg;

    // Fixed-point constants.
    localparam logic [63:0] PI_Q47  = 64'h0001_921F_B544_42D1;
    localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] SMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN    = 64'h8000_0000_0000_0000;

    // Taylor series: nine steps, row 0 for the cosine, row 1 for the sine.
    localparam int SER_STEPS = 9;
    localparam int LOG_ITERS = 32;

    // Divisors (n+1)(n+2) of each series step.
    localparam logic [8:0] SER_DIV [2][SER_STEPS] = '{
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306},
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342}
    };

    // Reciprocals floor(2^64 / d); the quotient estimate is low by at most one.
    localparam logic [63:0] SER_RECIP [2][SER_STEPS] = '{
        '{64'h8000_0000_0000_0000,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd12,  64'hFFFF_FFFF_FFFF_FFFF / 64'd30,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd56,  64'hFFFF_FFFF_FFFF_FFFF / 64'd90,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd132, 64'hFFFF_FFFF_FFFF_FFFF / 64'd182,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd240, 64'hFFFF_FFFF_FFFF_FFFF / 64'd306},
        '{64'hFFFF_FFFF_FFFF_FFFF / 64'd6,   64'hFFFF_FFFF_FFFF_FFFF / 64'd20,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd42,  64'hFFFF_FFFF_FFFF_FFFF / 64'd72,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd110, 64'hFFFF_FFFF_FFFF_FFFF / 64'd156,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd210, 64'hFFFF_FFFF_FFFF_FFFF / 64'd272,
          64'hFFFF_FFFF_FFFF_FFFF / 64'd342}
    };

    // Configuration register indexes.
    typedef enum logic [3:0] {
        CFG_DENSITY     = 4'd0,
        CFG_GB_SQUARED  = 4'd1,
        CFG_CUTOFF      = 4'd2,
        CFG_EDGE_PROJ   = 4'd3,
        CFG_SCREW_PROJ  = 4'd4,
        CFG_EDGE_CONST  = 4'd5,
        CFG_EDGE_COS    = 4'd6,
        CFG_SCREW_COEF  = 4'd7
    } t_cfg_idx;

    // Input request.
    typedef struct packed {
        logic [31:0] radius;
        logic [15:0] angle;
    } t_in;

    // Result.
    typedef struct packed {
        logic signed [63:0] t_value;
        logic               saturated;
    } t_out;

    // One term as sign, infinity flag and magnitude.
    typedef struct packed {
        logic        neg;
        logic        inf;
        logic [63:0] mag;
    } t_term;

    // Running state of the series between steps.
    typedef struct packed {
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] x2;
        logic        odd;
    } t_ser;

endpackage

// File: hw/rtl/dce_mul64.sv
// Two-stage 64 by 64 bit unsigned multiplier built from four 32 by 32 partial products.
module dce_mul64 (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);

    logic [63:0]  r_ll;
    logic [63:0]  r_lh;
    logic [63:0]  r_hl;
    logic [63:0]  r_hh;
    logic [127:0] r_p;

    // First stage forms the partial products, second stage adds them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0]  * i_b[31:0];
            r_lh <= i_a[31:0]  * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_hh <= i_a[63:32] * i_b[63:32];
            r_p  <= {r_hh, 64'b0} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0}
                    + {64'b0, r_ll};
        end
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/dce_sstep.sv
// One step of the sine or cosine Taylor series: multiply, exact divide, accumulate.
module dce_sstep import dce_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [3:0] i_k,
    input  t_ser       i_s,
    output t_ser       o_s
);

    logic [127:0] w_pa;
    logic [127:0] w_pb;
    logic [63:0]  w_t;
    logic [63:0]  w_q0;
    logic [72:0]  w_qd;
    logic [63:0]  w_rem;
    logic [8:0]   w_div;
    t_ser         r_sd [4];
    logic [63:0]  r_t [2];
    t_ser         r_s5;
    logic [63:0]  r_q;
    t_ser         r_out;

    // Next power of x: (term * x^2) >> 62.
    dce_mul64 u_mul_term (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_s.term),
        .i_b   (i_s.x2),
        .o_p   (w_pa)
    );
    assign w_t = w_pa[125:62];

    // Quotient estimate by the reciprocal of the step divisor.
    dce_mul64 u_mul_recip (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_t),
        .i_b   (SER_RECIP[r_sd[1].odd][i_k]),
        .o_p   (w_pb)
    );
    assign w_q0 = w_pb[127:64];

    // Remainder check lifts the estimate by one where it fell short.
    assign w_div = SER_DIV[r_sd[3].odd][i_k];
    assign w_qd  = w_q0 * w_div;
    assign w_rem = r_t[1] - w_qd[63:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_s;
            r_sd[1] <= r_sd[0];
            r_sd[2] <= r_sd[1];
            r_sd[3] <= r_sd[2];
            r_t[0]  <= w_t;
            r_t[1]  <= r_t[0];
            r_q     <= w_q0 + {63'b0, (w_rem >= {55'b0, w_div})};
            r_s5    <= r_sd[3];
        end
    end

    // Alternating sign: the first, third, ... steps subtract, clamped at zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.term <= r_q;
            r_out.x2   <= r_s5.x2;
            r_out.odd  <= r_s5.odd;
            if (!i_k[0]) begin
                r_out.acc <= (r_q > r_s5.acc) ? 64'b0 : r_s5.acc - r_q;
            end else begin
                r_out.acc <= r_s5.acc + r_q;
            end
        end
    end

    assign o_s = r_out;

endmodule

// File: hw/rtl/dce_cossq.sv
// Squared cosine of a 16-bit angle in Q0.32, by a pipelined Taylor series.
module dce_cossq import dce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_angle,
    output logic [32:0] o_cos2
);

    logic [14:0]  w_a15;
    logic [14:0]  w_af;
    logic         w_odd;
    logic [13:0]  w_v;
    logic [62:0]  w_x;
    logic [63:0]  r_x;
    logic         r_odd;
    logic [63:0]  r_xd [2];
    logic         r_od [2];
    logic [127:0] w_p2;
    t_ser         w_s [SER_STEPS + 1];
    logic [63:0]  w_c;
    logic [127:0] w_pc;

    // Fold the angle into the first octant and pick cosine or sine series.
    always_comb begin
        w_a15 = i_angle[14:0];
        w_af  = (w_a15 > 15'd16384) ? 15'(16'd32768 - {1'b0, w_a15}) : w_a15;
        w_odd = (w_af > 15'd8192);
        w_v   = w_odd ? 14'(15'd16384 - w_af) : w_af[13:0];
        w_x   = w_v * PI_Q47[48:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= {1'b0, w_x};
            r_odd   <= w_odd;
            r_xd[0] <= r_x;
            r_xd[1] <= r_xd[0];
            r_od[0] <= r_odd;
            r_od[1] <= r_od[0];
        end
    end

    // x squared in Q0.62.
    dce_mul64 u_mul_x2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_x),
        .i_b   (r_x),
        .o_p   (w_p2)
    );

    // Series seed: x for the sine, one for the cosine.
    always_comb begin
        w_s[0].term = r_od[1] ? r_xd[1] : ONE_Q62;
        w_s[0].acc  = r_od[1] ? r_xd[1] : ONE_Q62;
        w_s[0].x2   = w_p2[125:62];
        w_s[0].odd  = r_od[1];
    end

    // Chain of series steps.
    for (genvar j = 0; j < SER_STEPS; j++) begin : g_step
        dce_sstep u_step (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_k   (4'(j)),
            .i_s   (w_s[j]),
            .o_s   (w_s[j + 1])
        );
    end

    // Clamp to one and square.
    assign w_c = (w_s[SER_STEPS].acc > ONE_Q62) ? ONE_Q62 : w_s[SER_STEPS].acc;

    dce_mul64 u_mul_c2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_c),
        .i_b   (w_c),
        .o_p   (w_pc)
    );

    assign o_cos2 = w_pc[124:92];

endmodule

// File: hw/rtl/dce_log2.sv
// Base-2 logarithm of a 128-bit integer with 32 fraction bits, one squaring per two stages.
module dce_log2 import dce_pkg::*; (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [127:0] i_v,
    output logic [63:0]  o_log
);

    logic [3:0]   w_nz;
    logic [4:0]   w_pos [4];
    logic [3:0]   r_nz;
    logic [4:0]   r_pos [4];
    logic [127:0] r_v1;
    logic [6:0]   w_e;
    logic [6:0]   r_e2;
    logic [127:0] r_v2;
    logic [127:0] w_sh;
    logic [63:0]  r_m3;
    logic [6:0]   r_e3;
    logic [63:0]  w_m [LOG_ITERS + 1];
    logic [31:0]  w_frac [LOG_ITERS + 1];
    logic [6:0]   w_e_it [LOG_ITERS + 1];
    logic [63:0]  r_log;

    // Leading one of each 32-bit chunk.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_nz[c]  = |i_v[32*c +: 32];
            w_pos[c] = '0;
            for (int b = 0; b < 32; b++) begin
                if (i_v[32*c + b]) begin
                    w_pos[c] = 5'(b);
                end
            end
        end
    end

    // Combine the chunk results into the exponent.
    always_comb begin
        if (r_nz[3]) begin
            w_e = {2'd3, r_pos[3]};
        end else if (r_nz[2]) begin
            w_e = {2'd2, r_pos[2]};
        end else if (r_nz[1]) begin
            w_e = {2'd1, r_pos[1]};
        end else begin
            w_e = {2'd0, r_pos[0]};
        end
    end

    // Mantissa normalized to Q1.62.
    assign w_sh = r_v2 << (7'd127 - r_e2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nz  <= w_nz;
            r_pos <= w_pos;
            r_v1  <= i_v;
            r_e2  <= w_e;
            r_v2  <= r_v1;
            r_m3  <= {1'b0, w_sh[127:65]};
            r_e3  <= r_e2;
        end
    end

    assign w_m[0]    = r_m3;
    assign w_frac[0] = '0;
    assign w_e_it[0] = r_e3;

    // Each squaring yields one fraction bit, most significant first.
    for (genvar i = 0; i < LOG_ITERS; i++) begin : g_sq
        logic [127:0] w_p;
        logic [63:0]  w_sq;
        logic [6:0]   r_ed [2];
        logic [31:0]  r_fd [2];

        dce_mul64 u_sq (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (w_m[i]),
            .i_b   (w_m[i]),
            .o_p   (w_p)
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ed[0] <= w_e_it[i];
                r_ed[1] <= r_ed[0];
                r_fd[0] <= w_frac[i];
                r_fd[1] <= r_fd[0];
            end
        end

        assign w_sq          = w_p[125:62];
        assign w_m[i + 1]    = w_sq[63] ? {1'b0, w_sq[63:1]} : w_sq;
        assign w_frac[i + 1] = r_fd[1] | ({31'b0, w_sq[63]} << (31 - i));
        assign w_e_it[i + 1] = r_ed[1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_log <= {25'b0, w_e_it[LOG_ITERS], w_frac[LOG_ITERS]};
        end
    end

    assign o_log = r_log;

endmodule

// File: hw/rtl/dce_term.sv
// Magnitude of one correlation term: three chained truncating products with overflow tracking.
module dce_term import dce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_chi,
    input  logic        i_neg,
    input  logic [63:0] i_ln,
    input  logic [63:0] i_r2,
    input  logic [63:0] i_m1,
    input  logic        i_m1_ovf,
    input  logic        i_gb_zero,
    output t_term       o_term
);

    logic [127:0] w_pa;
    logic [127:0] w_pb;
    logic [127:0] w_pc;
    logic [63:0]  w_a;
    logic [63:0]  w_b;
    logic [63:0]  w_c;
    logic         w_ova;
    logic         w_ovb;
    logic         w_ovc;
    logic [63:0]  r_r2d [2];
    logic [63:0]  r_lnd [4];
    logic         r_ova [2];
    logic         r_ovb [2];
    logic         r_zd [6];
    logic         r_nd [6];
    t_term        r_term;

    // Density and gb product times the orientation factor.
    dce_mul64 u_mul_a (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_m1),
        .i_b   (i_chi),
        .o_p   (w_pa)
    );
    assign w_a   = w_pa[95:32];
    assign w_ova = i_m1_ovf | (|w_pa[127:96]);

    // Times r squared.
    dce_mul64 u_mul_b (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_a),
        .i_b   (r_r2d[1]),
        .o_p   (w_pb)
    );
    assign w_b   = w_pb[95:32];
    assign w_ovb = r_ova[1] | (|w_pb[127:96]);

    // Times the logarithm.
    dce_mul64 u_mul_c (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (w_b),
        .i_b   (r_lnd[3]),
        .o_p   (w_pc)
    );
    assign w_c   = w_pc[95:32];
    assign w_ovc = r_ovb[1] | (|w_pc[127:96]);

    // Operand and flag alignment.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2d[0] <= i_r2;
            r_r2d[1] <= r_r2d[0];
            r_lnd[0] <= i_ln;
            for (int k = 1; k < 4; k++) begin
                r_lnd[k] <= r_lnd[k - 1];
            end
            r_ova[0] <= w_ova;
            r_ova[1] <= r_ova[0];
            r_ovb[0] <= w_ovb;
            r_ovb[1] <= r_ovb[0];
            r_zd[0]  <= i_gb_zero | (i_chi == 64'b0) | (i_ln == 64'b0);
            r_nd[0]  <= i_neg;
            for (int k = 1; k < 6; k++) begin
                r_zd[k] <= r_zd[k - 1];
                r_nd[k] <= r_nd[k - 1];
            end
        end
    end

    // A zero factor wins over overflow; overflow makes the term infinite.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zd[5]) begin
                r_term <= '{neg: 1'b0, inf: 1'b0, mag: 64'b0};
            end else if (w_ovc) begin
                r_term <= '{neg: r_nd[5], inf: 1'b1, mag: '1};
            end else begin
                r_term <= '{neg: r_nd[5] & (w_c != 64'b0), inf: 1'b0, mag: w_c};
            end
        end
    end

    assign o_term = r_term;

endmodule

// File: hw/rtl/dislocation_correlation_eval_core.sv
// Top level of the dislocation correlation evaluator: registers, log paths, terms and final sum.
// Throughput: one request per cycle while the output is not stalled; the chain of 32 mantissa
// squarings in each logarithm unit, two stages per squaring, sets most of the depth.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and all configuration registers.
module dislocation_correlation_eval_core import dce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]  r_density;
    logic [63:0]  r_gb_squared;
    logic [63:0]  r_cutoff;
    logic [63:0]  r_edge_proj;
    logic [63:0]  r_screw_proj;
    logic [63:0]  r_edge_const;
    logic [63:0]  r_edge_cos;
    logic [63:0]  r_screw_coef;
    logic [81:0]  r_vld;
    logic         w_en;
    logic [127:0] w_m1p;
    logic [127:0] w_pe;
    logic [127:0] w_ps;
    logic [127:0] r_pe;
    logic [127:0] r_ne;
    logic [127:0] r_ps;
    logic [127:0] r_ns;
    logic [63:0]  w_lne;
    logic [63:0]  w_lpe;
    logic [63:0]  w_lns;
    logic [63:0]  w_lps;
    logic [63:0]  r_de;
    logic [63:0]  r_ds;
    logic [127:0] w_lne_p;
    logic [127:0] w_lns_p;
    logic [32:0]  w_cos2;
    logic         w_c2neg;
    logic [63:0]  w_c2mag;
    logic [127:0] w_pp;
    logic [63:0]  w_p;
    logic [63:0]  r_chi;
    logic         r_chineg;
    logic [63:0]  r_chid [12];
    logic         r_cnd [12];
    logic [31:0]  r_rad [73];
    logic [63:0]  r_r2;
    logic         r_rz [8];
    logic         w_sneg;
    logic [63:0]  w_smag;
    t_term        w_te;
    t_term        w_ts;
    logic         w_edge_en;
    logic         w_screw_en;
    t_term        w_e;
    t_term        w_s;
    logic [64:0]  w_sum;
    logic [63:0]  w_mag;
    logic         w_neg;
    logic         w_big;
    t_out         w_res;
    t_out         r_out;

    // Configuration writes, taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_density    <= '0;
            r_gb_squared <= '0;
            r_cutoff     <= '0;
            r_edge_proj  <= '0;
            r_screw_proj <= '0;
            r_edge_const <= '0;
            r_edge_cos   <= '0;
            r_screw_coef <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DENSITY:    r_density    <= i_cfg_data;
                CFG_GB_SQUARED: r_gb_squared <= i_cfg_data;
                CFG_CUTOFF:     r_cutoff     <= i_cfg_data;
                CFG_EDGE_PROJ:  r_edge_proj  <= i_cfg_data;
                CFG_SCREW_PROJ: r_screw_proj <= i_cfg_data;
                CFG_EDGE_CONST: r_edge_const <= i_cfg_data;
                CFG_EDGE_COS:   r_edge_cos   <= i_cfg_data;
                CFG_SCREW_COEF: r_screw_coef <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global pipeline advance: move unless a finished result is held back.
    assign w_en       = !r_vld[81] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[80:0], i_in_valid};
        end
    end

    // Density times gb squared, from configuration only.
    dce_mul64 u_mul_m1 (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (r_density),
        .i_b   (r_gb_squared),
        .o_p   (w_m1p)
    );

    // Projection times radius for both terms.
    dce_mul64 u_mul_pe (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_edge_proj),
        .i_b   ({32'b0, i_in.radius}),
        .o_p   (w_pe)
    );

    dce_mul64 u_mul_ps (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_screw_proj),
        .i_b   ({32'b0, i_in.radius}),
        .o_p   (w_ps)
    );

    // Numerator of the log ratio: P plus the cutoff scaled to the same point.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pe <= w_pe;
            r_ne <= w_pe + {48'b0, r_cutoff, 16'b0};
            r_ps <= w_ps;
            r_ns <= w_ps + {48'b0, r_cutoff, 16'b0};
        end
    end

    dce_log2 u_log_ne (.i_clk(i_clk), .i_en(w_en), .i_v(r_ne), .o_log(w_lne));
    dce_log2 u_log_pe (.i_clk(i_clk), .i_en(w_en), .i_v(r_pe), .o_log(w_lpe));
    dce_log2 u_log_ns (.i_clk(i_clk), .i_en(w_en), .i_v(r_ns), .o_log(w_lns));
    dce_log2 u_log_ps (.i_clk(i_clk), .i_en(w_en), .i_v(r_ps), .o_log(w_lps));

    // Log difference, floored at zero, then scaled by ln 2.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_de <= (w_lne > w_lpe) ? w_lne - w_lpe : 64'b0;
            r_ds <= (w_lns > w_lps) ? w_lns - w_lps : 64'b0;
        end
    end

    dce_mul64 u_mul_lne (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_de),
        .i_b   (LN2_Q64),
        .o_p   (w_lne_p)
    );

    dce_mul64 u_mul_lns (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_ds),
        .i_b   (LN2_Q64),
        .o_p   (w_lns_p)
    );

    // Edge orientation factor from the squared cosine.
    dce_cossq u_cossq (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_in.angle),
        .o_cos2  (w_cos2)
    );

    assign w_c2neg = r_edge_cos[63];
    assign w_c2mag = w_c2neg ? 64'b0 - r_edge_cos : r_edge_cos;

    dce_mul64 u_mul_p (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_c2mag),
        .i_b   ({31'b0, w_cos2}),
        .o_p   (w_pp)
    );
    assign w_p = w_pp[95:32];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!w_c2neg) begin
                r_chi    <= r_edge_const + w_p;
                r_chineg <= 1'b0;
            end else if (w_p <= r_edge_const) begin
                r_chi    <= r_edge_const - w_p;
                r_chineg <= 1'b0;
            end else begin
                r_chi    <= w_p - r_edge_const;
                r_chineg <= 1'b1;
            end
            r_chid[0] <= r_chi;
            r_cnd[0]  <= r_chineg;
            for (int k = 1; k < 12; k++) begin
                r_chid[k] <= r_chid[k - 1];
                r_cnd[k]  <= r_cnd[k - 1];
            end
        end
    end

    // Radius carried to the term stage; r squared and zero radius formed there.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad[0] <= i_in.radius;
            for (int k = 1; k < 73; k++) begin
                r_rad[k] <= r_rad[k - 1];
            end
            r_r2    <= r_rad[72] * r_rad[72];
            r_rz[0] <= (r_rad[72] == 32'b0);
            for (int k = 1; k < 8; k++) begin
                r_rz[k] <= r_rz[k - 1];
            end
        end
    end

    // Screw orientation factor as sign and magnitude.
    assign w_sneg = r_screw_coef[63];
    assign w_smag = w_sneg ? 64'b0 - r_screw_coef : r_screw_coef;

    dce_term u_term_e (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_chi     (r_chid[11]),
        .i_neg     (r_cnd[11]),
        .i_ln      (w_lne_p[127:64]),
        .i_r2      (r_r2),
        .i_m1      (w_m1p[96:33]),
        .i_m1_ovf  (|w_m1p[127:97]),
        .i_gb_zero (r_gb_squared == 64'b0),
        .o_term    (w_te)
    );

    dce_term u_term_s (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_chi     (w_smag),
        .i_neg     (w_sneg),
        .i_ln      (w_lns_p[127:64]),
        .i_r2      (r_r2),
        .i_m1      (w_m1p[96:33]),
        .i_m1_ovf  (|w_m1p[127:97]),
        .i_gb_zero (r_gb_squared == 64'b0),
        .o_term    (w_ts)
    );

    // Term enables depend on configuration only.
    assign w_edge_en  = (r_edge_proj != 64'b0) && (r_density != 64'b0)
                        && (r_edge_const != 64'b0) && !r_edge_const[63];
    assign w_screw_en = (r_screw_proj != 64'b0) && (r_density != 64'b0);

    // Signed sum of the two terms with saturation; a zero radius gives zero.
    always_comb begin
        w_e   = w_edge_en  ? w_te : '{neg: 1'b0, inf: 1'b0, mag: 64'b0};
        w_s   = w_screw_en ? w_ts : '{neg: 1'b0, inf: 1'b0, mag: 64'b0};
        w_sum = {1'b0, w_e.mag} + {1'b0, w_s.mag};
        w_big = 1'b0;
        if (w_e.neg == w_s.neg) begin
            w_mag = w_sum[63:0];
            w_big = w_sum[64];
            w_neg = w_e.neg;
        end else if (w_e.mag >= w_s.mag) begin
            w_mag = w_e.mag - w_s.mag;
            w_neg = w_e.neg;
        end else begin
            w_mag = w_s.mag - w_e.mag;
            w_neg = w_s.neg;
        end

        if (r_rz[7]) begin
            w_res = '{t_value: 64'sd0, saturated: 1'b0};
        end else if (w_e.inf || w_s.inf) begin
            w_res.saturated = 1'b1;
            if (w_e.inf && w_s.inf && (w_e.neg != w_s.neg)) begin
                w_res.t_value = 64'sd0;
            end else if (w_e.inf ? w_e.neg : w_s.neg) begin
                w_res.t_value = SMIN;
            end else begin
                w_res.t_value = SMAX;
            end
        end else if (!w_neg) begin
            if (w_big || (w_mag > SMAX)) begin
                w_res = '{t_value: SMAX, saturated: 1'b1};
            end else begin
                w_res = '{t_value: w_mag, saturated: 1'b0};
            end
        end else begin
            if (w_big || (w_mag > SMIN)) begin
                w_res = '{t_value: SMIN, saturated: 1'b1};
            end else begin
                w_res = '{t_value: 64'b0 - w_mag, saturated: 1'b0};
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_vld[81];
    assign o_out       = r_out;

    // A clipped result is always one of the two limits or zero.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |->
            ($unsigned(o_out.t_value) == SMAX) || ($unsigned(o_out.t_value) == SMIN)
            || ($unsigned(o_out.t_value) == 64'b0))
        else $error("saturated result is not a limit or zero");

    // While the output is held back, no item moves inside the pipeline.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(r_vld))
        else $error("pipeline moved during an output stall");

endmodule

// File: sim/dce_checker.sv
// Channel monitor, fixed-point correlation predictor and result scoreboard.
module dce_checker import dce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_clipped
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic [63:0] density, gb_squared, cutoff, edge_proj, screw_proj;
    logic [63:0] edge_const, edge_cos, screw_coef;

    t_out expected_results[$];

    // Product shifted right by s; flags any bit lost above 64.
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s, inout logic ovf);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        if ((p >> (64 + s)) != 0)
            ovf = 1'b1;
        q = p >> s;
        return q[63:0];
    endfunction

    // Ten-term Taylor series in Q0.62 for cosine (odd=0) or sine (odd=1).
    function automatic logic [63:0] taylor(input logic [63:0] x, input logic odd);
        logic        junk;
        logic [63:0] x2, term, acc, n;
        junk = 1'b0;
        x2 = mul_shift(x, x, 62, junk);
        term = odd ? x : ONE_Q62;
        acc = term;
        n = odd ? 64'd1 : 64'd0;
        for (int k = 1; k <= 9; k++) begin
            term = mul_shift(term, x2, 62, junk) / ((n + 1) * (n + 2));
            n += 2;
            if (k % 2 == 1)
                acc = (term > acc) ? 64'd0 : acc - term;
            else
                acc += term;
        end
        return acc;
    endfunction

    // cos^2 of the angle in Q0.32.
    function automatic logic [63:0] cos_squared(input logic [15:0] angle);
        logic        junk;
        logic [63:0] a, c;
        junk = 1'b0;
        a = {49'd0, angle[14:0]};
        if (a > 16384)
            a = 32768 - a;
        if (a <= 8192)
            c = taylor(a * PI_Q47, 1'b0);
        else
            c = taylor((16384 - a) * PI_Q47, 1'b1);
        if (c > ONE_Q62)
            c = ONE_Q62;
        return mul_shift(c, c, 62, junk) >> 30;
    endfunction

    // log2 of a nonzero 128-bit integer with 32 fraction bits.
    function automatic logic [63:0] log2_fix(input logic [127:0] v);
        int           e;
        logic [127:0] sh, sq;
        logic [63:0]  m, frac;
        e = 0;
        for (int i = 0; i < 128; i++)
            if (v[i])
                e = i;
        sh = (e <= 62) ? (v << (62 - e)) : (v >> (e - 62));
        m = sh[63:0];
        frac = 64'd0;
        for (int i = 31; i >= 0; i--) begin
            sq = {64'd0, m} * {64'd0, m};
            m = sq[125:62];
            if (m[63]) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(e) << 32) | frac;
    endfunction

    // ln((cutoff/proj + r)/r) in Q32.32.
    function automatic logic [63:0] log_ratio(input logic [63:0] proj, input logic [63:0] r);
        logic [127:0] p, n, prod;
        logic [63:0]  ln_n, ln_p, diff;
        p = {64'd0, proj} * {64'd0, r};
        n = p + ({64'd0, cutoff} << 16);
        ln_n = log2_fix(n);
        ln_p = log2_fix(p);
        diff = (ln_n > ln_p) ? ln_n - ln_p : 64'd0;
        prod = {64'd0, diff} * {64'd0, LN2_Q64};
        return prod[127:64];
    endfunction

    // One correlation term as sign, infinity and magnitude.
    function automatic t_term corr_term(input logic neg, input logic [63:0] chi,
                                        input logic [63:0] ln, input logic [63:0] r2);
        t_term       t;
        logic        ovf;
        logic [63:0] m;
        t = '0;
        ovf = 1'b0;
        if (gb_squared == 0 || chi == 0 || ln == 0)
            return t;
        m = mul_shift(density, gb_squared, 33, ovf);
        m = mul_shift(m, chi, 32, ovf);
        m = mul_shift(m, r2, 32, ovf);
        m = mul_shift(m, ln, 32, ovf);
        t.neg = neg;
        if (ovf) begin
            t.inf = 1'b1;
            t.mag = '1;
        end else begin
            t.mag = m;
            if (m == 0)
                t.neg = 1'b0;
        end
        return t;
    endfunction

    // Full evaluation of one request.
    function automatic t_out correlation(input t_in req);
        t_out        res;
        t_term       e, s;
        logic [63:0] r, r2, p, chi, c2mag, smag, mag, sum;
        logic        junk, c2neg, chineg, neg, big;
        res = '0;
        e = '0;
        s = '0;
        junk = 1'b0;
        r = {32'd0, req.radius};
        if (r == 0)
            return res;
        r2 = r * r;
        if (edge_proj != 0 && density != 0 && edge_const != 0 && !edge_const[63]) begin
            c2neg = edge_cos[63];
            c2mag = c2neg ? -edge_cos : edge_cos;
            p = mul_shift(c2mag, cos_squared(req.angle), 32, junk);
            chineg = 1'b0;
            if (!c2neg)
                chi = edge_const + p;
            else if (p <= edge_const)
                chi = edge_const - p;
            else begin
                chi = p - edge_const;
                chineg = 1'b1;
            end
            e = corr_term(chineg, chi, log_ratio(edge_proj, r), r2);
        end
        if (screw_proj != 0 && density != 0) begin
            smag = screw_coef[63] ? -screw_coef : screw_coef;
            s = corr_term(screw_coef[63], smag, log_ratio(screw_proj, r), r2);
        end
        if (e.inf || s.inf) begin
            res.saturated = 1'b1;
            if (e.inf && s.inf && e.neg != s.neg)
                res.t_value = '0;
            else
                res.t_value = (e.inf ? e.neg : s.neg) ? SMIN : SMAX;
            return res;
        end
        big = 1'b0;
        if (e.neg == s.neg) begin
            sum = e.mag + s.mag;
            big = sum < e.mag;
            mag = sum;
            neg = e.neg;
        end else if (e.mag >= s.mag) begin
            mag = e.mag - s.mag;
            neg = e.neg;
        end else begin
            mag = s.mag - e.mag;
            neg = s.neg;
        end
        if (!neg) begin
            if (big || mag > SMAX) begin
                res.t_value = SMAX;
                res.saturated = 1'b1;
            end else
                res.t_value = mag;
        end else begin
            if (big || mag > SMIN) begin
                res.t_value = SMIN;
                res.saturated = 1'b1;
            end else
                res.t_value = -mag;
        end
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // Track configuration, predict on each request, compare each result.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            {density, gb_squared, cutoff, edge_proj} <= '0;
            {screw_proj, edge_const, edge_cos, screw_coef} <= '0;
            expected_results.delete();
            o_errors <= 0;
            o_results <= 0;
            o_clipped <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DENSITY:    density    <= i_cfg_data;
                    CFG_GB_SQUARED: gb_squared <= i_cfg_data;
                    CFG_CUTOFF:     cutoff     <= i_cfg_data;
                    CFG_EDGE_PROJ:  edge_proj  <= i_cfg_data;
                    CFG_SCREW_PROJ: screw_proj <= i_cfg_data;
                    CFG_EDGE_CONST: edge_const <= i_cfg_data;
                    CFG_EDGE_COS:   edge_cos   <= i_cfg_data;
                    CFG_SCREW_COEF: screw_coef <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(correlation(i_in));
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (i_out.saturated)
                    o_clipped <= o_clipped + 1;
                if (expected_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result with nothing expected: t_value %h sat %b",
                                 $realtime, i_out.t_value, i_out.saturated);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.t_value !== i_out.t_value || want.saturated !== i_out.saturated)
                    begin
                        if (o_errors < 10)
                            $display("%0t: mismatch: t_value exp %h got %h, sat exp %b got %b",
                                     $realtime, want.t_value, i_out.t_value,
                                     want.saturated, i_out.saturated);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench top: clock, reset, configuration phases, request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dce_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 120;
    localparam int          HOLD_CYCLES    = 400;
    localparam logic [3:0]  CFG_UNUSED_IDX = 4'd13;
    localparam logic [63:0] ONE_Q32        = 64'h1_0000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    int          errors, pending, results, clipped;
    int          requests_sent = 0;
    int          idle_cycles = 0;

    dislocation_correlation_eval_core uut (.*);

    dce_checker u_checker (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_in,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out(o_out),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_clipped(clipped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Register write over the configuration channel.
    task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [63:0] dens, input logic [63:0] gb,
                             input logic [63:0] cut, input logic [63:0] eproj,
                             input logic [63:0] sproj, input logic [63:0] c1,
                             input logic [63:0] c2, input logic [63:0] cs);
        write_reg(CFG_DENSITY, dens);
        write_reg(CFG_GB_SQUARED, gb);
        write_reg(CFG_CUTOFF, cut);
        write_reg(CFG_EDGE_PROJ, eproj);
        write_reg(CFG_SCREW_PROJ, sproj);
        write_reg(CFG_EDGE_CONST, c1);
        write_reg(CFG_EDGE_COS, c2);
        write_reg(CFG_SCREW_COEF, cs);
    endtask

    // Offer one request; valid stays high so back-to-back requests stream.
    task automatic send_request(input logic [31:0] radius, input logic [15:0] angle);
        i_in_valid <= 1'b1;
        i_in.radius <= radius;
        i_in.angle <= angle;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
    endtask

    // Random gap between bursts, valid low meanwhile.
    task automatic burst_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait for every outstanding result, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Radii spread over magnitudes, with the occasional zero and full scale.
    function automatic logic [31:0] rand_radius();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom >> $urandom_range(8, 30);
        endcase
    endfunction

    task automatic random_burst(input int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int i = $urandom_range(1, 20); i > 0 && left > 0; i--) begin
                send_request(rand_radius(), 16'($urandom));
                left--;
            end
            burst_gap();
        end
    endtask

    // Receiver: random stall pattern with changing duty, one long hold-off.
    initial begin
        int  mode;
        bit  held;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            // Hold off only while the sender is offering, so the pipeline backs up.
            if (!held && results > 150 && i_in_valid) begin
                held = 1'b1;
                @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        logic [15:0] angles[8];
        angles = '{16'd0, 16'd8192, 16'd16384, 16'd24576, 16'd32768, 16'd4096, 16'd12000,
                   16'd65535};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: both terms disabled.
        send_request(32'd5, 16'd0);
        send_request(32'hFFFF_FFFF, 16'hFFFF);
        drain();

        // Moderate physical setup: directed radii and angles.
        write_all(ONE_Q32, ONE_Q32, 64'd100 << 32, ONE_Q32, 64'd2 << 32,
                  ONE_Q32 >> 1, -(ONE_Q32 >> 2), ONE_Q32 >> 1);
        write_reg(CFG_UNUSED_IDX, rand_word());
        foreach (angles[i])
            send_request(32'h0001_0000, angles[i]);
        send_request(32'd0, 16'd100);
        send_request(32'd1, 16'd0);
        send_request(32'hFFFF_FFFF, 16'd0);
        send_request(32'h0000_8000, 16'd3000);
        drain();

        // Edge factor crossing zero; negative edge constant disables the edge term.
        write_reg(CFG_EDGE_COS, -(ONE_Q32 << 1));
        send_request(32'h0002_0000, 16'd0);
        send_request(32'h0002_0000, 16'd16384);
        drain();
        write_reg(CFG_EDGE_CONST, 64'h8000_0000_0000_0000);
        send_request(32'h0002_0000, 16'd0);
        drain();

        // Full-scale registers: both terms overflow with opposite signs, then equal signs.
        write_all('1, '1, '1, 64'd1, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        send_request(32'h0001_0000, 16'd0);
        send_request(32'hFFFF_FFFF, 16'd8192);
        drain();
        write_reg(CFG_SCREW_COEF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(32'h0001_0000, 16'd0);
        drain();
        write_reg(CFG_GB_SQUARED, 64'd0);
        send_request(32'h0001_0000, 16'd0);
        drain();

        // Random phases: mostly moderate settings, some fully random.
        for (int phase = 0; phase < 7; phase++) begin
            if (phase % 3 == 2)
                write_all(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word());
            else
                write_all(64'($urandom) >> $urandom_range(0, 24),
                          64'($urandom) << $urandom_range(0, 16),
                          64'($urandom) << $urandom_range(0, 24),
                          ($urandom_range(0, 5) == 0) ? 64'd0 : 64'($urandom) << 8,
                          ($urandom_range(0, 5) == 0) ? 64'd0 : 64'($urandom) << 8,
                          {{32{$urandom_range(0, 4) == 0}}, $urandom},
                          {{32{$urandom_range(0, 1) == 0}}, $urandom},
                          {{32{$urandom_range(0, 1) == 0}}, $urandom});
            random_burst(95);
            drain();
        end

        $display("Covered %0d requests and %0d results over nine register settings;",
                 requests_sent, results);
        $display("%0d results were clipped, with a long output hold-off along the way.",
                 clipped);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dce_pkg.sv
hw/rtl/dce_mul64.sv
hw/rtl/dce_sstep.sv
hw/rtl/dce_cossq.sv
hw/rtl/dce_log2.sv
hw/rtl/dce_term.sv
hw/rtl/dislocation_correlation_eval_core.sv
sim/dce_checker.sv
sim/tb_top.sv
